[src/kil_pkg.sv]
// shared constants and types for the keyframe interval locator
package kil_pkg;

   localparam int MAX_FRAMES  = 256;
   localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
   localparam int COUNT_W     = 9;
   localparam int VERTEX_W    = 16;
   localparam int TIME_W      = 32;
   localparam int WEIGHT_W    = 17;
   localparam int FACTOR_W    = 10;
   localparam int PRODUCT_W   = VERTEX_W + FACTOR_W;
   localparam int OFFSET_W    = 28;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      REG_FRAME_COUNT  = 1'b0,
      REG_VERTEX_COUNT = 1'b1
   } reg_index_type;

endpackage

[src/kil_divider.sv]
// iterative restoring divider for the q1.16 blend weight, one quotient bit per cycle
module kil_divider
   import kil_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [TIME_W-1:0]   dividend,
   input  logic [TIME_W-1:0]   divisor,
   output logic                done,
   output logic [WEIGHT_W-1:0] quotient
);

   localparam int STEP_W = $clog2(WEIGHT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WEIGHT_W - 1);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   count_ff, count_in;
   logic [TIME_W:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]   den_ff, den_in;
   logic [WEIGHT_W-1:0] quot_ff, quot_in;
   logic                fits;
   logic [TIME_W:0]     diff;

   always_comb begin
      fits     = rem_ff >= {1'b0, den_ff};
      diff     = fits ? rem_ff - {1'b0, den_ff} : rem_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         rem_in   = {1'b0, dividend};
         den_in   = divisor;
         quot_in  = '0;
      end else if (run_ff) begin
         rem_in   = {diff[TIME_W-1:0], 1'b0};
         quot_in  = {quot_ff[WEIGHT_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done longer than one cycle");

   a_done_after_run : assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(run_ff))
      else $error("divider done without a running division");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> count_ff <= LAST_STEP)
      else $error("divider step count out of range");

endmodule

[src/keyframe_interval_locator.sv]
// keyframe interval locator top level: time table memory, search sequencer, offsets, csr port
// a write item gives no result; a query reads the first entry, which may decide at once,
// else scans with one memory read per entry until interval (k-1,k) is found, then runs
// the divider, or until it passes the last of n frames. busy stays high until the result
// strobe; the result register frees the block so the next item may start in the strobe
// cycle.
// reset clears control state and sets frame_count to 1, vertex_count to 0; table unset
module keyframe_interval_locator
   import kil_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic [FRAME_IDX_W-1:0] req_entry_index,
   input  logic signed [TIME_W-1:0] req_time_value,
   output logic                   rsp_valid,
   output logic [FRAME_IDX_W-1:0] rsp_frame_a,
   output logic [FRAME_IDX_W-1:0] rsp_frame_b,
   output logic [WEIGHT_W-1:0]    rsp_blend_weight,
   output logic [OFFSET_W-1:0]    rsp_offset_a,
   output logic [OFFSET_W-1:0]    rsp_offset_b,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_W-1:0]      paddr,
   input  logic [DATA_W-1:0]      pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SCAN,
      ST_DIV,
      ST_OFFSET
   } state_type;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAMES);

   logic [TIME_W-1:0] time_mem [MAX_FRAMES];

   state_type              state_ff, state_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [TIME_W-1:0]      prev_ff, prev_in;
   logic [FRAME_IDX_W-1:0] last_ff, last_in;
   logic [FRAME_IDX_W-1:0] k_ff, k_in;
   logic [FRAME_IDX_W-1:0] fa_ff, fa_in;
   logic [FRAME_IDX_W-1:0] fb_ff, fb_in;
   logic [WEIGHT_W-1:0]    weight_ff, weight_in;
   logic [TIME_W-1:0]      rdata_ff;
   logic [COUNT_W-1:0]     frame_count_ff, frame_count_in;
   logic [VERTEX_W-1:0]    vertex_count_ff, vertex_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_IDX_W-1:0] rsp_frame_a_ff, rsp_frame_b_ff;
   logic [WEIGHT_W-1:0]    rsp_weight_ff;
   logic [OFFSET_W-1:0]    rsp_offset_a_ff, rsp_offset_b_ff;

   logic                   accept;
   logic                   is_query;
   logic                   cfg_write;
   reg_index_type          cfg_index;
   logic [FRAME_IDX_W-1:0] rd_addr;
   logic [COUNT_W-1:0]     last_count;
   logic                   t_le_entry;
   logic [TIME_W:0]        num_wide, den_wide;
   logic                   div_start;
   logic                   div_done;
   logic [WEIGHT_W-1:0]    div_quotient;
   logic [FACTOR_W-1:0]    factor_a, factor_b;
   logic [PRODUCT_W-1:0]   product_a, product_b;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_query  = (opcode_type'(req_opcode) == OP_QUERY);
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[2]);
   assign pready    = 1'b1;

   always_comb begin
      unique case (cfg_index)
         REG_FRAME_COUNT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, frame_count_ff};
         REG_VERTEX_COUNT: prdata = {{(DATA_W-VERTEX_W){1'b0}}, vertex_count_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (frame_count_ff == '0) begin
         last_count = '0;
      end else if (frame_count_ff > MAX_COUNT) begin
         last_count = MAX_COUNT - 1'b1;
      end else begin
         last_count = frame_count_ff - 1'b1;
      end
   end

   assign t_le_entry = $signed(time_ff) <= $signed(rdata_ff);
   assign num_wide   = {time_ff[TIME_W-1], time_ff} - {prev_ff[TIME_W-1], prev_ff};
   assign den_wide   = {rdata_ff[TIME_W-1], rdata_ff} - {prev_ff[TIME_W-1], prev_ff};

   kil_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_wide[TIME_W-1:0]),
      .divisor  (den_wide[TIME_W-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in        = state_ff;
      time_in         = time_ff;
      prev_in         = prev_ff;
      last_in         = last_ff;
      k_in            = k_ff;
      fa_in           = fa_ff;
      fb_in           = fb_ff;
      weight_in       = weight_ff;
      rd_addr         = '0;
      div_start       = 1'b0;
      rsp_valid_in    = 1'b0;
      frame_count_in  = frame_count_ff;
      vertex_count_in = vertex_count_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_FRAME_COUNT:  frame_count_in = pwdata[COUNT_W-1:0];
            REG_VERTEX_COUNT: vertex_count_in = pwdata[VERTEX_W-1:0];
            default:          frame_count_in = frame_count_ff;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               time_in  = req_time_value;
               last_in  = last_count[FRAME_IDX_W-1:0];
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (last_ff == '0 || t_le_entry) begin
               fa_in     = '0;
               fb_in     = '0;
               weight_in = '0;
               state_in  = ST_OFFSET;
            end else begin
               prev_in  = rdata_ff;
               k_in     = FRAME_IDX_W'(1);
               rd_addr  = FRAME_IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (t_le_entry) begin
               fa_in     = k_ff - 1'b1;
               fb_in     = k_ff;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (k_ff == last_ff) begin
               fa_in     = last_ff;
               fb_in     = last_ff;
               weight_in = '0;
               state_in  = ST_OFFSET;
            end else begin
               prev_in  = rdata_ff;
               k_in     = k_ff + 1'b1;
               rd_addr  = k_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               weight_in = div_quotient;
               state_in  = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign factor_a  = {2'b00, fa_ff} + {1'b0, fa_ff, 1'b0} + FACTOR_W'(2);
   assign factor_b  = {2'b00, fb_ff} + {1'b0, fb_ff, 1'b0} + FACTOR_W'(2);
   assign product_a = {{FACTOR_W{1'b0}}, vertex_count_ff} * {{VERTEX_W{1'b0}}, factor_a};
   assign product_b = {{FACTOR_W{1'b0}}, vertex_count_ff} * {{VERTEX_W{1'b0}}, factor_b};

   always_ff @(posedge clock) begin
      if (accept && !is_query) begin
         time_mem[req_entry_index] <= req_time_value;
      end
      rdata_ff <= time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         frame_count_ff  <= COUNT_W'(1);
         vertex_count_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_count_ff  <= frame_count_in;
         vertex_count_ff <= vertex_count_in;
      end
      time_ff   <= time_in;
      prev_ff   <= prev_in;
      last_ff   <= last_in;
      k_ff      <= k_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      weight_ff <= weight_in;
      if (rsp_valid_in) begin
         rsp_frame_a_ff  <= fa_ff;
         rsp_frame_b_ff  <= fb_ff;
         rsp_weight_ff   <= weight_ff;
         rsp_offset_a_ff <= {product_a, 2'b00};
         rsp_offset_b_ff <= {product_b, 2'b00};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_a      = rsp_frame_a_ff;
   assign rsp_frame_b      = rsp_frame_b_ff;
   assign rsp_blend_weight = rsp_weight_ff;
   assign rsp_offset_a     = rsp_offset_a_ff;
   assign rsp_offset_b     = rsp_offset_b_ff;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      accept && is_query |=> busy)
      else $error("query accepted but block not busy");

   a_pair_adjacent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frame_b_ff == rsp_frame_a_ff)
         || (rsp_frame_b_ff == rsp_frame_a_ff + 1'b1))
      else $error("frame pair not adjacent");

   a_same_frame_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_frame_a_ff == rsp_frame_b_ff) |-> rsp_weight_ff == '0)
      else $error("nonzero weight for a single frame");

   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_weight_ff <= WEIGHT_W'(65536))
      else $error("blend weight above one");

endmodule

[sim/tb_keyframe_interval_locator.sv]
// testbench for the keyframe interval locator: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_keyframe_interval_locator;
   import kil_pkg::*;

   localparam int ITEM_TARGET = 750;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [FRAME_IDX_W-1:0] frame_a;
      logic [FRAME_IDX_W-1:0] frame_b;
      logic [WEIGHT_W-1:0]    blend_weight;
      logic [OFFSET_W-1:0]    offset_a;
      logic [OFFSET_W-1:0]    offset_b;
   } interval_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_opcode;
   logic [FRAME_IDX_W-1:0]   req_entry_index;
   logic signed [TIME_W-1:0] req_time_value;
   logic                     rsp_valid;
   logic [FRAME_IDX_W-1:0]   rsp_frame_a;
   logic [FRAME_IDX_W-1:0]   rsp_frame_b;
   logic [WEIGHT_W-1:0]      rsp_blend_weight;
   logic [OFFSET_W-1:0]      rsp_offset_a;
   logic [OFFSET_W-1:0]      rsp_offset_b;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [DATA_W-1:0]        pwdata;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // predictor state
   logic signed [TIME_W-1:0] kf_time [MAX_FRAMES];
   bit                       kf_written [MAX_FRAMES];
   logic [COUNT_W-1:0]       frame_count;
   logic [VERTEX_W-1:0]      vertex_count;

   interval_type pending_intervals[$];
   interval_type oldest;
   int        fail_count;
   int        items_sent;
   int        burst_left;
   int        idle_cycles;

   keyframe_interval_locator uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_frame_a      (rsp_frame_a),
      .rsp_frame_b      (rsp_frame_b),
      .rsp_blend_weight (rsp_blend_weight),
      .rsp_offset_a     (rsp_offset_a),
      .rsp_offset_b     (rsp_offset_b),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [OFFSET_W-1:0] frame_offset(logic [FRAME_IDX_W-1:0] frame);
      longint unsigned off;
      off = 64'd4 * vertex_count * (64'd2 + 64'd3 * frame);
      return off[OFFSET_W-1:0];
   endfunction

   function automatic interval_type locate_interval(logic signed [TIME_W-1:0] tq);
      interval_type r;
      int        n;
      bit        found;
      longint    tp;
      longint    tk;
      longint    num;
      longint    den;
      n = (frame_count == 0) ? 1 : ((frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count);
      r = '0;
      found = 0;
      if (n > 1 && tq > kf_time[0]) begin
         for (int k = 1; k < n && !found; k++) begin
            if (tq <= kf_time[k]) begin
               tp = kf_time[k-1];
               tk = kf_time[k];
               num = longint'(tq) - tp;
               den = tk - tp;
               r.frame_a = FRAME_IDX_W'(k - 1);
               r.frame_b = FRAME_IDX_W'(k);
               r.blend_weight = (den != 0) ? WEIGHT_W'((num <<< 16) / den) : '0;
               found = 1;
            end
         end
         if (!found) begin
            r.frame_a = FRAME_IDX_W'(n - 1);
            r.frame_b = FRAME_IDX_W'(n - 1);
         end
      end
      r.offset_a = frame_offset(r.frame_a);
      r.offset_b = frame_offset(r.frame_b);
      return r;
   endfunction

   task automatic note_mismatch(string what);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_intervals.size() == 0) begin
            note_mismatch("result with no query outstanding");
         end else begin
            oldest = pending_intervals.pop_front();
            if (rsp_frame_a !== oldest.frame_a || rsp_frame_b !== oldest.frame_b ||
                rsp_blend_weight !== oldest.blend_weight ||
                rsp_offset_a !== oldest.offset_a || rsp_offset_b !== oldest.offset_b)
               note_mismatch($sformatf(
                  "exp a=%0d b=%0d w=%0d oa=%0d ob=%0d got a=%0d b=%0d w=%0d oa=%0d ob=%0d",
                  oldest.frame_a, oldest.frame_b, oldest.blend_weight, oldest.offset_a,
                  oldest.offset_b, rsp_frame_a, rsp_frame_b, rsp_blend_weight,
                  rsp_offset_a, rsp_offset_b));
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_keyframe_interval_locator NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(opcode_type op, logic [FRAME_IDX_W-1:0] idx,
                            logic signed [TIME_W-1:0] tv);
      req_opcode      <= op;
      req_entry_index <= idx;
      req_time_value  <= tv;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == OP_WRITE) begin
         kf_time[idx]    = tv;
         kf_written[idx] = 1;
      end else begin
         pending_intervals.push_back(locate_interval(tv));
      end
      // sender bursts and gaps
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_intervals.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      burst_left = $urandom_range(1, 6);
   endtask

   task automatic csr_write(reg_index_type which, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] readback;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({which, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (which == REG_FRAME_COUNT) begin
         frame_count = value[COUNT_W-1:0];
         readback = DATA_W'(frame_count);
      end else begin
         vertex_count = value[VERTEX_W-1:0];
         readback = DATA_W'(vertex_count);
      end
      // read back the same register
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== readback)
         note_mismatch($sformatf("register %0d read exp %0h got %0h", which, readback, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_single_frame();
      csr_write(REG_FRAME_COUNT, 1);
      csr_write(REG_VERTEX_COUNT, 0);
      send_item(OP_WRITE, 8'd0, 32'h0001_0000);
      send_item(OP_QUERY, 8'hff, 32'h8000_0000);
      send_item(OP_QUERY, 8'h00, 32'h7fff_ffff);
      send_item(OP_QUERY, 8'h5a, 32'h0000_8000);
   endtask

   task automatic test_interval_edges();
      csr_write(REG_FRAME_COUNT, 4);
      csr_write(REG_VERTEX_COUNT, 16'hffff);
      send_item(OP_WRITE, 8'd0, 32'h8000_0000);
      send_item(OP_WRITE, 8'd1, 32'hffff_0000);
      send_item(OP_WRITE, 8'd2, 32'h0003_8000);
      send_item(OP_WRITE, 8'd3, 32'h7fff_ffff);
      send_item(OP_QUERY, 8'h00, 32'h8000_0001);
      send_item(OP_QUERY, 8'h11, 32'hffff_0000);
      send_item(OP_QUERY, 8'h22, 32'h0001_0000);
      send_item(OP_QUERY, 8'h33, 32'h0003_8001);
      send_item(OP_QUERY, 8'hff, 32'h7fff_ffff);
   endtask

   task automatic test_unsorted_table();
      csr_write(REG_FRAME_COUNT, 5);
      csr_write(REG_VERTEX_COUNT, 1000);
      send_item(OP_WRITE, 8'd0, 32'd10 << 16);
      send_item(OP_WRITE, 8'd1, 32'd5 << 16);
      send_item(OP_WRITE, 8'd2, 32'd20 << 16);
      send_item(OP_WRITE, 8'd3, 32'd1 << 16);
      send_item(OP_WRITE, 8'd4, 32'd30 << 16);
      send_item(OP_QUERY, 8'h00, 32'd15 << 16);
      send_item(OP_QUERY, 8'h00, 32'd40 << 16);
      send_item(OP_QUERY, 8'h00, 32'd3 << 16);
      send_item(OP_QUERY, 8'h00, 32'd20 << 16);
   endtask

   task automatic test_frame_count_limits();
      csr_write(REG_FRAME_COUNT, 0);
      send_item(OP_QUERY, 8'h00, 32'd15 << 16);
      csr_write(REG_FRAME_COUNT, 2);
      send_item(OP_QUERY, 8'h00, 32'd7 << 16);
      send_item(OP_QUERY, 8'h00, 32'd12 << 16);
   endtask

   function automatic logic signed [TIME_W-1:0] clamp_time(longint v);
      if (v > 64'sd2147483647)
         return 32'h7fff_ffff;
      if (v < -64'sd2147483648)
         return 32'h8000_0000;
      return v[TIME_W-1:0];
   endfunction

   function automatic logic signed [TIME_W-1:0] pick_query_time(int n);
      int     j;
      longint lo;
      longint span;
      case ($urandom_range(0, 9))
         0: return clamp_time(longint'(kf_time[0]) - $urandom_range(0, 70000));
         1: return clamp_time(longint'(kf_time[n-1]) + $urandom_range(1, 70000));
         2: return kf_time[$urandom_range(0, n - 1)];
         3, 4: return $urandom;
         default: begin
            j = (n > 1) ? $urandom_range(1, n - 1) : 0;
            lo = kf_time[(j > 0) ? j - 1 : 0];
            span = longint'(kf_time[j]) - lo;
            if (span <= 0)
               return kf_time[j];
            return clamp_time(lo + longint'({$urandom, $urandom} % (span + 1)));
         end
      endcase
   endfunction

   task automatic load_small_table(int n);
      int     vals[$];
      int     mode;
      longint center;
      longint spread;
      mode = $urandom_range(0, 9);
      center = longint'($signed($urandom));
      spread = (mode == 1) ? n : (64'd1 << $urandom_range(4, 31));
      for (int i = 0; i < n; i++) begin
         if (mode == 0)
            vals.push_back($urandom);
         else
            vals.push_back(clamp_time(center + longint'($urandom % spread)));
      end
      if (mode != 0)
         vals.sort();
      for (int i = 0; i < n; i++)
         send_item(OP_WRITE, FRAME_IDX_W'(i), vals[i]);
   endtask

   task automatic load_large_table();
      // ascending ramp for entries not yet written, then a few overwrites
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (!kf_written[i])
            send_item(OP_WRITE, FRAME_IDX_W'(i),
                      32'hc000_0000 + i * 32'h0080_0000 + $urandom_range(0, 32'h7f_ffff));
      end
      repeat ($urandom_range(1, 4)) begin
         send_item(OP_WRITE, FRAME_IDX_W'($urandom_range(1, MAX_FRAMES - 2)),
                   32'hc000_0000 + $urandom_range(0, 32'h7fff_ffff));
      end
   endtask

   task automatic test_random_phases();
      int phase;
      int fc;
      int n;
      int vc;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0)
            fc = MAX_FRAMES;
         else if (phase == 1)
            fc = 511;
         else if ($urandom_range(0, 9) == 0)
            fc = $urandom_range(17, 511);
         else
            fc = $urandom_range(0, 16);
         n = (fc == 0) ? 1 : ((fc > MAX_FRAMES) ? MAX_FRAMES : fc);
         case ($urandom_range(0, 9))
            0: vc = 0;
            1: vc = 16'hffff;
            default: vc = $urandom_range(0, 16'hffff);
         endcase
         if (phase == 0)
            vc = 16'hffff;
         csr_write(REG_FRAME_COUNT, fc);
         csr_write(REG_VERTEX_COUNT, vc);
         if (n <= 32)
            load_small_table(n);
         else
            load_large_table();
         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 7) == 0)
               send_item(OP_WRITE, FRAME_IDX_W'($urandom), $urandom);
            else
               send_item(OP_QUERY, FRAME_IDX_W'($urandom), pick_query_time(n));
         end
         phase++;
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= OP_WRITE;
      req_entry_index <= '0;
      req_time_value <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      fail_count      = 0;
      items_sent      = 0;
      burst_left      = 1;
      idle_cycles     = 0;
      frame_count     = 1;
      vertex_count    = 0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         kf_time[i]    = '0;
         kf_written[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_frame();
      test_interval_edges();
      test_unsorted_table();
      test_frame_count_limits();
      test_random_phases();

      start <= 1'b0;
      while (pending_intervals.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_keyframe_interval_locator OK");
      end else begin
         $display("tb_keyframe_interval_locator NOT OK");
      end
      $finish;
   end

endmodule

[keyframe_interval_locator.f]
src/kil_pkg.sv
src/kil_divider.sv
src/keyframe_interval_locator.sv
sim/tb_keyframe_interval_locator.sv
